// File: rtl/core/tnrx_pkg.sv
// tnrx_pkg: shared types and telnet protocol codes for the telnet receive negotiator
// no dependencies; imported by the top level and the port checker
package tnrx_pkg;

    typedef logic [7:0] t_byte;

    // byte parser state, one-hot
    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_IAC  = 3'b010,
        PH_OPT  = 3'b100
    } t_phase;

    typedef logic [2:0] t_verb;
    typedef logic [1:0] t_sink;
    typedef logic [3:0] t_count;

    // telnet command bytes
    localparam t_byte T_IAC  = 8'd255;
    localparam t_byte T_SB   = 8'd250;
    localparam t_byte T_SE   = 8'd240;
    localparam t_byte T_WILL = 8'd251;
    localparam t_byte T_WONT = 8'd252;
    localparam t_byte T_DO   = 8'd253;
    localparam t_byte T_DONT = 8'd254;

    // options
    localparam t_byte OPT_ECHO = 8'd1;
    localparam t_byte OPT_SUPP = 8'd3;
    localparam t_byte OPT_TERM = 8'd24;

    // terminal-type subnegotiation codes
    localparam t_byte TT_IS   = 8'd0;
    localparam t_byte TT_SEND = 8'd1;

    // terminal names
    localparam t_byte CH_N = 8'h4E;
    localparam t_byte CH_V = 8'h56;
    localparam t_byte CH_T = 8'h54;
    localparam t_byte CH_A = 8'h41;
    localparam t_byte CH_S = 8'h53;
    localparam t_byte CH_I = 8'h49;

    // pending verb codes
    localparam t_verb PV_SB   = 3'd0;
    localparam t_verb PV_WILL = 3'd1;
    localparam t_verb PV_WONT = 3'd2;
    localparam t_verb PV_DO   = 3'd3;
    localparam t_verb PV_DONT = 3'd4;

    // where plain bytes go
    localparam t_sink SINK_TERM    = 2'd0;
    localparam t_sink SINK_DISCARD = 2'd1;
    localparam t_sink SINK_TTYPE   = 2'd2;

    // output kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // longest burst of beats caused by one received byte
    localparam int BURST_MAX = 10;

endpackage

// File: rtl/core/telnet_rx_option_negotiator_top.sv
// telnet_rx_option_negotiator_top: iac parser, option negotiator and beat burst buffer
// depends on tnrx_pkg
//
// Takes one received telnet byte per input beat and produces zero to ten output beats.
// IAC framing is stripped (IAC IAC gives a literal 255), plain bytes leave as terminal data
// tagged with the terminal kind latched at the last IAC SE, and WILL/WONT/DO/DONT for
// ECHO, SUPPRESS-GO-AHEAD and TERMINAL-TYPE are answered with reply beats; other options
// are refused. TERMINAL-TYPE SEND is answered with IS NVT or IS ANSI following a three-step
// rotation, and subnegotiation of any other option is discarded up to IAC SE.
// All decoding for a byte is done in the cycle it is accepted: the parser state updates at
// once and the whole reply is loaded into a ten-entry shift buffer that drains one beat per
// cycle unless the output stalls. Bytes that give at most one beat each stream at one per
// clock unless the output stalls; a byte that gives more beats keeps the input stalled
// while the buffer drains. The next byte is taken in the same cycle that the last beat of
// the previous burst is taken. last_of_run marks the final beat of each burst; bytes that
// cause no beat leave no trace on the output.
module telnet_rx_option_negotiator_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tnrx_pkg::t_byte i_rx_byte,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tnrx_pkg::t_byte o_out_byte,
    output logic           o_out_kind,
    output logic           o_terminal_kind,
    output logic           o_echo_on,
    output logic           o_line_mode_on,
    output logic           o_last_of_run
);
    import tnrx_pkg::*;

    // parser and negotiation state
    t_phase r_phase, n_phase;
    t_verb  r_verb,  n_verb;
    t_sink  r_sink,  n_sink;
    logic [1:0] r_rot, n_rot;
    logic   r_term,  n_term;
    logic   r_echo,  n_echo;
    logic   r_line,  n_line;

    // burst buffer: entry 0 is the beat on offer
    t_byte  r_buf [BURST_MAX];
    t_count r_cnt;
    logic   r_kind;
    logic   r_bk_term;
    logic   r_bk_echo;
    logic   r_bk_line;

    // burst computed for the byte on the input
    t_byte  v_buf [BURST_MAX];
    t_count v_n;
    logic   v_kind;
    logic   v_do_sink;
    logic   v_neg;

    logic   w_in_acc;
    logic   w_out_acc;

    // accept a byte when the buffer is empty or its last beat leaves this cycle
    assign o_in_stall = (r_cnt > 4'd1) || ((r_cnt == 4'd1) && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 4'd0);
    assign w_out_acc  = o_out_valid && !i_out_stall;

    always_comb begin
        n_phase   = PH_DATA;
        n_verb    = r_verb;
        n_sink    = r_sink;
        n_rot     = r_rot;
        n_term    = r_term;
        n_echo    = r_echo;
        n_line    = r_line;
        v_do_sink = 1'b0;
        v_neg     = 1'b0;
        v_n       = 4'd0;
        v_kind    = KIND_REPLY;
        for (int i = 0; i < BURST_MAX; i++) begin
            v_buf[i] = 8'h00;
        end

        // byte parser
        unique case (r_phase)
            PH_IAC: begin
                if (i_rx_byte == T_IAC) begin
                    v_do_sink = 1'b1;
                end else if (i_rx_byte == T_SE) begin
                    // any se restores the terminal and latches the kind
                    n_sink = SINK_TERM;
                    n_term = (r_rot != 2'd0);
                end else if (i_rx_byte == T_SB) begin
                    n_verb  = PV_SB;
                    n_phase = PH_OPT;
                end else if (i_rx_byte >= T_WILL) begin
                    n_verb  = 3'(i_rx_byte - T_WILL) + 3'd1;
                    n_phase = PH_OPT;
                end
            end
            PH_OPT: begin
                if ((r_verb >= PV_WILL) && (r_verb <= PV_DONT)) begin
                    v_neg = 1'b1;
                end else begin
                    n_sink = (i_rx_byte == OPT_TERM) ? SINK_TTYPE : SINK_DISCARD;
                end
            end
            default: begin
                if (i_rx_byte == T_IAC) begin
                    n_phase = PH_IAC;
                end else begin
                    v_do_sink = 1'b1;
                end
            end
        endcase

        // plain byte routing
        if (v_do_sink) begin
            if (r_sink == SINK_TERM) begin
                v_buf[0] = i_rx_byte;
                v_kind   = KIND_DATA;
                v_n      = 4'd1;
            end else if ((r_sink == SINK_TTYPE) && (i_rx_byte == TT_SEND)) begin
                n_rot    = (r_rot >= 2'd2) ? 2'd0 : r_rot + 2'd1;
                v_buf[0] = T_IAC;
                v_buf[1] = T_SB;
                v_buf[2] = OPT_TERM;
                v_buf[3] = TT_IS;
                if (n_rot == 2'd0) begin
                    v_buf[4] = CH_N;
                    v_buf[5] = CH_V;
                    v_buf[6] = CH_T;
                    v_buf[7] = T_IAC;
                    v_buf[8] = T_SE;
                    v_n      = 4'd9;
                end else begin
                    v_buf[4] = CH_A;
                    v_buf[5] = CH_N;
                    v_buf[6] = CH_S;
                    v_buf[7] = CH_I;
                    v_buf[8] = T_IAC;
                    v_buf[9] = T_SE;
                    v_n      = 4'd10;
                end
            end
        end

        // option negotiation, replies are iac verb option
        if (v_neg) begin
            v_buf[0] = T_IAC;
            v_buf[2] = i_rx_byte;
            if (i_rx_byte == OPT_ECHO) begin
                case (r_verb)
                    PV_WILL: begin
                        if (r_echo) begin
                            n_echo   = 1'b0;
                            v_buf[1] = T_DO;
                            v_n      = 4'd3;
                        end
                    end
                    PV_WONT: begin
                        if (!r_echo) begin
                            n_echo   = 1'b1;
                            v_buf[1] = T_DONT;
                            v_n      = 4'd3;
                        end
                    end
                    default: begin
                        v_buf[1] = T_WONT;
                        v_n      = 4'd3;
                    end
                endcase
            end else if (i_rx_byte == OPT_SUPP) begin
                case (r_verb)
                    PV_WILL: begin
                        // character mode: accept sga both ways and ask for remote echo
                        if (r_line) begin
                            n_line   = 1'b0;
                            n_echo   = 1'b0;
                            v_buf[1] = T_DO;
                            v_buf[3] = T_IAC;
                            v_buf[4] = T_WILL;
                            v_buf[5] = OPT_SUPP;
                            v_buf[6] = T_IAC;
                            v_buf[7] = T_DO;
                            v_buf[8] = OPT_ECHO;
                            v_n      = 4'd9;
                        end
                    end
                    PV_WONT: begin
                        if (!r_line) begin
                            n_line   = 1'b1;
                            v_buf[1] = T_DONT;
                            v_buf[3] = T_IAC;
                            v_buf[4] = T_WONT;
                            v_buf[5] = OPT_SUPP;
                            v_n      = 4'd6;
                        end
                    end
                    PV_DO: begin
                        if (r_line) begin
                            v_buf[1] = T_DO;
                            v_n      = 4'd3;
                        end
                    end
                    default: begin
                        if (!r_line) begin
                            v_buf[1] = T_DONT;
                            v_n      = 4'd3;
                        end
                    end
                endcase
            end else begin
                if (r_verb == PV_WILL) begin
                    v_buf[1] = T_DONT;
                    v_n      = 4'd3;
                end else if (r_verb == PV_DO) begin
                    v_buf[1] = (i_rx_byte == OPT_TERM) ? T_WILL : T_WONT;
                    v_n      = 4'd3;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_verb  <= PV_SB;
            r_sink  <= SINK_TERM;
            r_rot   <= 2'd0;
            r_term  <= 1'b0;
            r_echo  <= 1'b1;
            r_line  <= 1'b1;
            r_cnt   <= 4'd0;
        end else begin
            if (w_in_acc) begin
                r_phase <= n_phase;
                r_verb  <= n_verb;
                r_sink  <= n_sink;
                r_rot   <= n_rot;
                r_term  <= n_term;
                r_echo  <= n_echo;
                r_line  <= n_line;
                r_cnt   <= v_n;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    // burst payload: load on accept, shift one entry per taken beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < BURST_MAX; i++) begin
                r_buf[i] <= v_buf[i];
            end
            r_kind    <= v_kind;
            r_bk_term <= n_term;
            r_bk_echo <= n_echo;
            r_bk_line <= n_line;
        end else if (w_out_acc) begin
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    assign o_out_byte      = r_buf[0];
    assign o_out_kind      = r_kind;
    assign o_terminal_kind = r_bk_term;
    assign o_echo_on       = r_bk_echo;
    assign o_line_mode_on  = r_bk_line;
    assign o_last_of_run   = (r_cnt == 4'd1);

endmodule

// File: rtl/core/tnrx_checker.sv
// tnrx_checker: port-level assertions for the telnet receive negotiator, with its bind
// depends on tnrx_pkg and telnet_rx_option_negotiator_top
module tnrx_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_stall,
    input tnrx_pkg::t_byte o_out_byte,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic            o_out_kind,
    input logic            o_last_of_run
);
    import tnrx_pkg::*;

    // a held beat keeps its byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled beat changed");

    // a new byte only enters when the burst is empty or its last beat leaves
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> o_in_stall)
        else $error("input taken in the middle of a burst");

    // terminal data is always a single-beat burst
    a_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind == KIND_DATA)) |-> o_last_of_run)
        else $error("terminal data beat not last of run");

    // an empty output side never stalls the input
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with nothing to send");

    // a taken beat that is not the last is followed by more of the same burst
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> o_out_valid)
        else $error("burst ended early");

endmodule

bind telnet_rx_option_negotiator_top tnrx_checker u_tnrx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_byte    (o_out_byte),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_kind    (o_out_kind),
    .o_last_of_run (o_last_of_run)
);

// File: sim/tb_top.sv
// tb_top: self-checking bench for the telnet receive option negotiator
// depends on tnrx_pkg and telnet_rx_option_negotiator_top; uses no files or arguments
// a byte-level predictor builds the expected beats, which are compared with the dut output
module tb_top;

    import tnrx_pkg::*;

    // one expected output beat
    typedef struct packed {
        t_byte data;
        logic  kind;
        logic  term;
        logic  echo;
        logic  line;
        logic  last;
    } t_beat;

    localparam int CYC_LIMIT   = 100000;
    localparam int SETTLE_CYCS = 20;
    localparam int RAND_BYTES  = 175;

    // dut ports
    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    t_byte rx_byte   = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_byte out_byte;
    logic  out_kind;
    logic  term_kind;
    logic  echo_on;
    logic  line_on;
    logic  last_run;

    // bench bookkeeping
    t_byte stim_q[$];          // bytes still to be offered to the dut
    t_beat reply_q[$];         // beats the dut still owes us
    int    rx_taken  = 0;      // received bytes accepted so far
    int    errors    = 0;
    int    cyc       = 0;
    int    hold_left = 0;
    logic  hold_done = 1'b0;
    int    rand_cnt;
    int    pick;
    int    body_len;
    t_byte pb;

    // no random idling on either side over this window of accepted bytes
    wire calm = (rx_taken >= 150 && rx_taken < 210);

    telnet_rx_option_negotiator_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_byte      (out_byte),
        .o_out_kind      (out_kind),
        .o_terminal_kind (term_kind),
        .o_echo_on       (echo_on),
        .o_line_mode_on  (line_on),
        .o_last_of_run   (last_run)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // negotiator state as the bench sees it
    // ------------------------------------------------------------------
    t_phase     ph;
    t_verb      pend_verb;
    t_sink      sink;
    logic [1:0] term_rot;
    logic       term_latch;
    logic       echo_flag;
    logic       line_flag;

    // beats produced by the byte being decoded
    t_byte burst_b[BURST_MAX];
    logic  burst_k[BURST_MAX];
    int    burst_n;

    task automatic add_beat(input t_byte b, input logic k);
        if (burst_n < BURST_MAX) begin
            burst_b[burst_n] = b;
            burst_k[burst_n] = k;
            burst_n++;
        end
    endtask

    // IAC <verb> <option> back to the server
    task automatic add_cmd(input t_byte verb, input t_byte opt);
        add_beat(T_IAC, KIND_REPLY);
        add_beat(verb, KIND_REPLY);
        add_beat(opt, KIND_REPLY);
    endtask

    // a plain byte goes wherever the current sink points
    task automatic route_byte(input t_byte b);
        if (sink == SINK_TERM) begin
            add_beat(b, KIND_DATA);
        end else if (sink == SINK_TTYPE && b == TT_SEND) begin
            // rotation runs 0 -> 1 -> 2 -> 0, anything but 0 names ANSI
            term_rot = (term_rot >= 2'd2) ? 2'd0 : term_rot + 2'd1;
            add_beat(T_IAC, KIND_REPLY);
            add_beat(T_SB, KIND_REPLY);
            add_beat(OPT_TERM, KIND_REPLY);
            add_beat(TT_IS, KIND_REPLY);
            if (term_rot == 2'd0) begin
                add_beat(CH_N, KIND_REPLY);
                add_beat(CH_V, KIND_REPLY);
                add_beat(CH_T, KIND_REPLY);
            end else begin
                add_beat(CH_A, KIND_REPLY);
                add_beat(CH_N, KIND_REPLY);
                add_beat(CH_S, KIND_REPLY);
                add_beat(CH_I, KIND_REPLY);
            end
            add_beat(T_IAC, KIND_REPLY);
            add_beat(T_SE, KIND_REPLY);
        end
        // discard sink, and non-SEND bytes in terminal-type sink, are dropped
    endtask

    task automatic negotiate(input t_verb verb, input t_byte opt);
        if (opt == OPT_ECHO) begin
            case (verb)
                PV_WILL: begin
                    if (echo_flag) begin
                        echo_flag = 1'b0;
                        add_cmd(T_DO, opt);
                    end
                end
                PV_WONT: begin
                    if (!echo_flag) begin
                        echo_flag = 1'b1;
                        add_cmd(T_DONT, opt);
                    end
                end
                default: add_cmd(T_WONT, opt);
            endcase
        end else if (opt == OPT_SUPP) begin
            case (verb)
                PV_WILL: begin
                    // server goes character mode: echo off as well
                    if (line_flag) begin
                        line_flag = 1'b0;
                        echo_flag = 1'b0;
                        add_cmd(T_DO, OPT_SUPP);
                        add_cmd(T_WILL, OPT_SUPP);
                        add_cmd(T_DO, OPT_ECHO);
                    end
                end
                PV_WONT: begin
                    if (!line_flag) begin
                        line_flag = 1'b1;
                        add_cmd(T_DONT, OPT_SUPP);
                        add_cmd(T_WONT, OPT_SUPP);
                    end
                end
                // DO and DONT are echoed back only when the line flag agrees
                PV_DO: begin
                    if (line_flag) add_cmd(T_DO, OPT_SUPP);
                end
                default: begin
                    if (!line_flag) add_cmd(T_DONT, OPT_SUPP);
                end
            endcase
        end else if (opt == OPT_TERM) begin
            if (verb == PV_WILL) add_cmd(T_DONT, opt);
            else if (verb == PV_DO) add_cmd(T_WILL, opt);
        end else begin
            // unknown option: refuse
            if (verb == PV_WILL) add_cmd(T_DONT, opt);
            else if (verb == PV_DO) add_cmd(T_WONT, opt);
        end
    endtask

    // decode one accepted byte and queue the beats it should cause
    task automatic decode_rx_byte(input t_byte b);
        t_beat bt;
        burst_n = 0;
        case (ph)
            PH_IAC: begin
                ph = PH_DATA;
                if (b == T_IAC) begin
                    route_byte(b);
                end else if (b == T_SE) begin
                    sink       = SINK_TERM;
                    term_latch = (term_rot != 2'd0);
                end else if (b == T_SB) begin
                    pend_verb = PV_SB;
                    ph        = PH_OPT;
                end else if (b >= T_WILL) begin
                    pend_verb = t_verb'(b - T_WILL + 8'd1);
                    ph        = PH_OPT;
                end
                // any other command is swallowed
            end
            PH_OPT: begin
                ph = PH_DATA;
                if (pend_verb >= PV_WILL && pend_verb <= PV_DONT) begin
                    negotiate(pend_verb, b);
                end else begin
                    sink = (b == OPT_TERM) ? SINK_TTYPE : SINK_DISCARD;
                end
            end
            default: begin
                if (b == T_IAC) ph = PH_IAC;
                else route_byte(b);
            end
        endcase
        // status fields carry the state after the whole byte
        for (int k = 0; k < burst_n; k++) begin
            bt.data = burst_b[k];
            bt.kind = burst_k[k];
            bt.term = term_latch;
            bt.echo = echo_flag;
            bt.line = line_flag;
            bt.last = (k == burst_n - 1);
            reply_q.push_back(bt);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued bytes, idling at random
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
                in_valid <= 1'b1;
                rx_byte  <= stim_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output stall: random idling plus one long hold-off mid-run, during which
    // the driver keeps offering so the burst buffer fills and backs up
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (!hold_done && rx_taken == 120) begin
                hold_left <= 150;
                hold_done <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            out_stall <= (hold_left > 1) || (!calm && $urandom_range(0, 99) < 16);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted byte, then checks each taken beat
    // ------------------------------------------------------------------
    always @(posedge clk) begin : mon
        t_beat want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                decode_rx_byte(rx_byte);
                rx_taken <= rx_taken + 1;
            end
            if (out_valid && !out_stall) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected beat: out_byte %0d kind %0d", out_byte, out_kind);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("out_byte", want.data, out_byte);
                    check_field("out_kind", want.kind, out_kind);
                    check_field("terminal_kind", want.term, term_kind);
                    check_field("echo_on", want.echo, echo_on);
                    check_field("line_mode_on", want.line, line_on);
                    check_field("last_of_run", want.last, last_run);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus: queue is filled here on falling edges; the driver pops it on rising edges
    // ------------------------------------------------------------------
    initial begin
        // predictor state out of reset
        ph         = PH_DATA;
        pend_verb  = PV_SB;
        sink       = SINK_TERM;
        term_rot   = 2'd0;
        term_latch = 1'b0;
        echo_flag  = 1'b1;
        line_flag  = 1'b1;

        // directed: data extremes, escaped 255, echo and sga handshakes,
        // terminal-type send at full burst length, latch at SE, plain command,
        // refusal of an unknown option
        stim_q = '{8'h00, 8'hFE,
                   T_IAC, T_IAC,
                   T_IAC, T_WILL, OPT_ECHO,
                   T_IAC, T_WILL, OPT_SUPP,
                   T_IAC, T_SB, OPT_TERM, TT_SEND, 8'd7, T_IAC, T_SE,
                   8'h78,
                   T_IAC, T_WONT, OPT_SUPP,
                   T_IAC, 8'd241,
                   T_IAC, T_DO, 8'd99};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sender holds back until every owed beat has come out
        do @(negedge clk); while (stim_q.size() != 0 || in_valid || reply_q.size() != 0);

        // random part: mostly well-formed telnet sequences, some noise
        rand_cnt = 0;
        while (rand_cnt < RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // data byte, 255 escaped
                pb = t_byte'($urandom);
                stim_q.push_back(pb);
                if (pb == T_IAC) stim_q.push_back(T_IAC);
            end else if (pick < 55) begin
                // option negotiation
                stim_q.push_back(T_IAC);
                stim_q.push_back(t_byte'($urandom_range(T_WILL, T_DONT)));
                case ($urandom_range(0, 3))
                    0: stim_q.push_back(OPT_ECHO);
                    1: stim_q.push_back(OPT_SUPP);
                    2: stim_q.push_back(OPT_TERM);
                    default: stim_q.push_back(t_byte'($urandom));
                endcase
            end else if (pick < 78) begin
                // subnegotiation, terminal-type mostly, closed by IAC SE most times
                stim_q.push_back(T_IAC);
                stim_q.push_back(T_SB);
                stim_q.push_back((pick < 70) ? OPT_TERM : t_byte'($urandom));
                body_len = $urandom_range(1, 4);
                repeat (body_len) begin
                    pb = ($urandom_range(0, 1) != 0) ? TT_SEND : t_byte'($urandom);
                    stim_q.push_back(pb);
                    if (pb == T_IAC) stim_q.push_back(T_IAC);
                end
                if ($urandom_range(0, 9) != 0) begin
                    stim_q.push_back(T_IAC);
                    stim_q.push_back(T_SE);
                end
            end else if (pick < 85) begin
                // stray SE without SB
                stim_q.push_back(T_IAC);
                stim_q.push_back(T_SE);
            end else if (pick < 92) begin
                // other commands, including codes below SE
                stim_q.push_back(T_IAC);
                stim_q.push_back(($urandom_range(0, 1) != 0) ?
                                 t_byte'($urandom_range(241, 249)) :
                                 t_byte'($urandom_range(0, 239)));
            end else begin
                // noise: IAC plus anything, or a bare random byte
                if ($urandom_range(0, 1) != 0) stim_q.push_back(T_IAC);
                stim_q.push_back(t_byte'($urandom));
            end
            rand_cnt = stim_q.size();
        end

        // wait for the last byte to go in and the last beat to come out
        do @(negedge clk); while (stim_q.size() != 0 || in_valid || reply_q.size() != 0);
        repeat (SETTLE_CYCS) @(negedge clk);
        if (reply_q.size() != 0) begin
            $error("%0d expected beats never arrived", reply_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
